### sv/kms_pkg.sv
// Shared types, constants and translation tables for the key matrix scanner.
package kms_pkg;

  localparam int KEY_BYTES = 16;
  localparam int LANES = 8;
  localparam int RES_SLOTS = LANES + 1;
  localparam int REPEAT_SLOT = LANES;
  localparam int IDX_W = $clog2(KEY_BYTES);
  localparam int SLOT_W = $clog2(RES_SLOTS);
  localparam int CODE_W = 7;

  localparam logic [IDX_W-1:0] LAST_BYTE = IDX_W'(KEY_BYTES - 1);
  localparam logic [7:0] NO_KEY = 8'hff;
  localparam logic [7:0] UNMAPPED = 8'hff;
  localparam logic [15:0] RESET_DELAY_MS = 16'd500;
  localparam logic [15:0] RESET_INTERVAL_MS = 16'd40;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_ACTIVATE = 2'd1,
    OP_DEACTIVATE = 2'd2
  } op_t;

  localparam logic REG_INITIAL_DELAY = 1'b0;
  localparam logic REG_REPEAT_INTERVAL = 1'b1;

  localparam logic [7:0] KEY_ROM [128] = '{
    8'h1d, 8'h1e, 8'h1f, 8'h20, 8'h22, 8'h21, 8'h29, 8'h2a,
    8'h2b, 8'h2c, 8'hff, 8'h2d, 8'h10, 8'h11, 8'h12, 8'h13,
    8'h15, 8'h14, 8'h01, 8'h02, 8'h03, 8'h04, 8'h06, 8'h05,
    8'h0c, 8'h09, 8'h07, 8'h0b, 8'h08, 8'h0a, 8'h1b, 8'h18,
    8'h16, 8'h1a, 8'h17, 8'h19, 8'h1c, 8'h25, 8'h23, 8'h27,
    8'h24, 8'h26, 8'h28, 8'h30, 8'h32, 8'h2e, 8'h2f, 8'h31,
    8'h0f, 8'h34, 8'hff, 8'h0e, 8'hff, 8'h00, 8'hff, 8'hff,
    8'h70, 8'h79, 8'h73, 8'h74, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'h50, 8'hff, 8'h45, 8'hff, 8'h49, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'h41, 8'h1c, 8'hff, 8'h40, 8'h3e,
    8'hff, 8'h4d, 8'h4e, 8'h4a, 8'h4b, 8'h4c, 8'h46, 8'h47,
    8'h48, 8'h42, 8'hff, 8'h43, 8'h44, 8'h0d, 8'h33, 8'h4f,
    8'h66, 8'h67, 8'h68, 8'h64, 8'h69, 8'h6a, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h6b, 8'hff, 8'hff,
    8'hff, 8'hff, 8'h3f, 8'h3e, 8'h37, 8'h39, 8'h65, 8'h3f,
    8'h63, 8'h36, 8'h62, 8'h3b, 8'h3c, 8'h3d, 8'h3a, 8'hff
  };

  // bit (7 - code[2:0]) of row code[6:3] marks a repeating code
  localparam logic [7:0] REPEAT_ROM [16] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f,
    8'hff, 8'hff, 8'hc1, 8'hff, 8'hc0, 8'h0f, 8'h07, 8'h07
  };

  typedef struct packed {
    logic hit;
    logic press;
    logic rep;
    logic [CODE_W-1:0] code;
  } lane_t;

  typedef struct packed {
    logic [7:0] rk_next;
    logic any_set;
    logic fire;
  } merge_t;

  typedef struct packed {
    logic [RES_SLOTS-1:0] mask;
    logic [RES_SLOTS-1:0] brk;
    logic all_rel;
    logic [RES_SLOTS-1:0][CODE_W-1:0] code;
  } res_t;

endpackage

### sv/kms_scan_if.sv
// Scan request channel carrying one scan byte or a control opcode.
interface kms_scan_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [3:0] byte_index;
  logic [7:0] key_bits;
  logic [31:0] now_ms;

  modport source(output valid, opcode, byte_index, key_bits, now_ms, input ready);
  modport sink(input valid, opcode, byte_index, key_bits, now_ms, output ready);
endinterface

### sv/kms_result_if.sv
// Result channel carrying one translated key code.
interface kms_result_if;
  logic valid;
  logic ready;
  logic [6:0] scancode;
  logic is_break;
  logic all_release;
  logic last;

  modport source(output valid, scancode, is_break, all_release, last, input ready);
  modport sink(input valid, scancode, is_break, all_release, last, output ready);
endinterface

### sv/kms_cfg_if.sv
// Configuration write channel: register index and write data.
interface kms_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/kms_lane.sv
// One key lane: change detect, code translation and repeat lookup for one bit.
module kms_lane (
  input  logic [kms_pkg::IDX_W-1:0] idx,
  input  logic [2:0] lane_no,
  input  logic changed,
  input  logic pressed,
  output kms_pkg::lane_t lane
);

  logic [7:0] rom_code;
  logic [7:0] rep_row;

  always_comb begin
    rom_code = kms_pkg::KEY_ROM[{idx, lane_no}];
    rep_row = kms_pkg::REPEAT_ROM[rom_code[6:3]];
    lane.hit = changed && (rom_code != kms_pkg::UNMAPPED);
    lane.press = pressed;
    lane.rep = pressed && rep_row[~rom_code[2:0]];
    lane.code = rom_code[kms_pkg::CODE_W-1:0];
  end

endmodule

### sv/kms_merge.sv
// Merge stage: fold lane events into the repeat key and decide the repeat.
module kms_merge (
  input  kms_pkg::lane_t lanes [kms_pkg::LANES],
  input  logic [kms_pkg::IDX_W-1:0] idx,
  input  logic [31:0] now_ms,
  input  logic [7:0] repeat_key,
  input  logic [31:0] repeat_base_ms,
  input  logic repeat_in_interval,
  input  logic [15:0] initial_delay_ms,
  input  logic [15:0] repeat_interval_ms,
  output kms_pkg::merge_t merge
);

  logic [7:0] rk;
  logic any_set;
  logic [31:0] elapsed;
  logic [15:0] delay;
  logic due_old;

  always_comb begin
    rk = repeat_key;
    any_set = 1'b0;
    for (int j = 0; j < kms_pkg::LANES; j++) begin
      if (lanes[j].hit) begin
        if (lanes[j].rep) begin
          rk = {1'b0, lanes[j].code};
          any_set = 1'b1;
        end else if (!lanes[j].press && (rk == {1'b0, lanes[j].code})) begin
          rk = kms_pkg::NO_KEY;
        end
      end
    end
  end

  // elapsed time against the stored base, ready in parallel with the fold
  always_comb begin
    elapsed = now_ms - repeat_base_ms;
    delay = repeat_in_interval ? repeat_interval_ms : initial_delay_ms;
    due_old = elapsed >= {16'd0, delay};
  end

  always_comb begin
    merge.rk_next = rk;
    merge.any_set = any_set;
    merge.fire = (idx == kms_pkg::LAST_BYTE) && (rk != kms_pkg::NO_KEY) &&
                 (any_set ? (initial_delay_ms == 16'd0) : due_old);
  end

endmodule

### sv/kms_emit.sv
// Result serializer: holds one item's result list and sends it in slot order.
module kms_emit (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  kms_pkg::res_t list,
  output logic free,
  kms_result_if.source result
);

  kms_pkg::res_t pend;
  logic [kms_pkg::SLOT_W-1:0] sel;
  logic [kms_pkg::RES_SLOTS-1:0] sel_hot;
  logic is_last;
  logic take;

  always_comb begin
    sel = '0;
    for (int i = kms_pkg::RES_SLOTS - 1; i >= 0; i--) begin
      if (pend.mask[i]) begin
        sel = kms_pkg::SLOT_W'(i);
      end
    end
    sel_hot = kms_pkg::RES_SLOTS'(1) << sel;
    is_last = (pend.mask & ~sel_hot) == '0;
    take = result.valid && result.ready;
    free = (pend.mask == '0) || (take && is_last);
  end

  assign result.valid = |pend.mask;
  assign result.scancode = pend.code[sel];
  assign result.is_break = pend.brk[sel];
  assign result.all_release = pend.all_rel;
  assign result.last = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.mask <= '0;
    end else if (load) begin
      pend.mask <= list.mask;
    end else if (take) begin
      pend.mask <= pend.mask & ~sel_hot;
    end
    if (load) begin
      pend.brk <= list.brk;
      pend.all_rel <= list.all_rel;
      pend.code <= list.code;
    end
  end

endmodule

### sv/key_matrix_scan_with_repeat.sv
// Top level of the key matrix scanner with typematic repeat.
// A request enters a one-stage decode register where eight key lanes compare the
// byte with the stored map, translate changed keys and feed a merge stage that
// updates the repeat key and decides an automatic repeat; all state is updated as
// the request leaves, and a new request may take its place. Results go to a
// serializer that sends one result per cycle while the result port is ready, so a
// request with k results (at most 9) holds the port until all are sent while the
// next is already decoded; requests with no result pass the serializer by.
// Configuration writes are always accepted and take effect on the next request.
module key_matrix_scan_with_repeat (
  input  logic clk,
  input  logic rst,
  kms_scan_if.sink scan,
  kms_result_if.source result,
  kms_cfg_if.sink cfg
);

  logic [7:0] key_map [kms_pkg::KEY_BYTES];
  logic active;
  logic [7:0] repeat_key;
  logic [31:0] repeat_base_ms;
  logic repeat_in_interval;
  logic [15:0] initial_delay_ms;
  logic [15:0] repeat_interval_ms;

  logic s1_valid;
  logic [1:0] s1_op;
  logic [kms_pkg::IDX_W-1:0] s1_idx;
  logic [7:0] s1_bits;
  logic [31:0] s1_now;

  logic [7:0] changed;
  kms_pkg::lane_t lanes [kms_pkg::LANES];
  kms_pkg::merge_t merge;
  kms_pkg::res_t list;
  logic is_scan;
  logic is_deact;
  logic emit_free;
  logic s1_fire;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay_ms <= kms_pkg::RESET_DELAY_MS;
      repeat_interval_ms <= kms_pkg::RESET_INTERVAL_MS;
    end else if (cfg.valid) begin
      case (cfg.index)
        kms_pkg::REG_INITIAL_DELAY: initial_delay_ms <= cfg.data;
        kms_pkg::REG_REPEAT_INTERVAL: repeat_interval_ms <= cfg.data;
        default: ;
      endcase
    end
  end

  assign scan.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_op <= scan.opcode;
      s1_idx <= scan.byte_index;
      s1_bits <= scan.key_bits;
      s1_now <= scan.now_ms;
    end
  end

  assign changed = key_map[s1_idx] ^ s1_bits;

  for (genvar j = 0; j < kms_pkg::LANES; j++) begin : g_lane
    kms_lane u_lane (
      .idx(s1_idx),
      .lane_no(3'(j)),
      .changed(changed[j]),
      .pressed(s1_bits[j]),
      .lane(lanes[j])
    );
  end

  kms_merge u_merge (
    .lanes(lanes),
    .idx(s1_idx),
    .now_ms(s1_now),
    .repeat_key(repeat_key),
    .repeat_base_ms(repeat_base_ms),
    .repeat_in_interval(repeat_in_interval),
    .initial_delay_ms(initial_delay_ms),
    .repeat_interval_ms(repeat_interval_ms),
    .merge(merge)
  );

  always_comb begin
    is_scan = (s1_op == kms_pkg::OP_SCAN) && active;
    is_deact = (s1_op == kms_pkg::OP_DEACTIVATE) && active;
    list.mask = '0;
    list.brk = '0;
    list.all_rel = is_deact;
    list.code = '0;
    if (is_deact) begin
      list.mask[0] = 1'b1;
    end else if (is_scan) begin
      for (int j = 0; j < kms_pkg::LANES; j++) begin
        list.mask[j] = lanes[j].hit;
        list.brk[j] = !lanes[j].press;
        list.code[j] = lanes[j].code;
      end
      list.mask[kms_pkg::REPEAT_SLOT] = merge.fire;
      list.code[kms_pkg::REPEAT_SLOT] = merge.rk_next[kms_pkg::CODE_W-1:0];
    end
    s1_fire = s1_valid && ((list.mask == '0) || emit_free);
  end

  kms_emit u_emit (
    .clk(clk),
    .rst(rst),
    .load(s1_fire && (list.mask != '0)),
    .list(list),
    .free(emit_free),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      repeat_key <= kms_pkg::NO_KEY;
      repeat_base_ms <= '0;
      repeat_in_interval <= 1'b0;
      for (int i = 0; i < kms_pkg::KEY_BYTES; i++) begin
        key_map[i] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_op == kms_pkg::OP_ACTIVATE) begin
        active <= 1'b1;
      end
      if (is_deact) begin
        active <= 1'b0;
        repeat_key <= kms_pkg::NO_KEY;
        for (int i = 0; i < kms_pkg::KEY_BYTES; i++) begin
          key_map[i] <= '0;
        end
      end
      if (is_scan) begin
        key_map[s1_idx] <= s1_bits;
        repeat_key <= merge.rk_next;
        if (merge.fire) begin
          repeat_base_ms <= s1_now;
          repeat_in_interval <= 1'b1;
        end else if (merge.any_set) begin
          repeat_base_ms <= s1_now;
          repeat_in_interval <= 1'b0;
        end
      end
    end
  end

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    repeat_key == kms_pkg::NO_KEY || !repeat_key[7])
    else $error("repeat key outside code range");

  a_idle_no_repeat: assert property (@(posedge clk) disable iff (rst)
    !active |-> repeat_key == kms_pkg::NO_KEY)
    else $error("repeat key held while inactive");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    scan.valid && scan.ready |=> s1_valid)
    else $error("accepted request lost before decode");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_idx) && $stable(s1_bits))
    else $error("decode stage changed while stalled");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the key matrix scanner with typematic repeat.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] ROW_NONE = 2'd0;
  localparam logic [1:0] ROW_ONE = 2'd1;
  localparam logic [1:0] ROW_MODEL = 2'd2;
  localparam int WALK_ROWS = 24;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 56;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [6:0] scancode;
    logic is_break;
    logic all_release;
    logic last;
  } key_res_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] idx;
    logic [7:0] bits;
    logic [31:0] now;
    logic [1:0] mode;
    key_res_t res;
  } walk_row_t;

  localparam logic [7:0] CODE_TABLE [128] = '{
    8'h1d, 8'h1e, 8'h1f, 8'h20, 8'h22, 8'h21, 8'h29, 8'h2a,
    8'h2b, 8'h2c, 8'hff, 8'h2d, 8'h10, 8'h11, 8'h12, 8'h13,
    8'h15, 8'h14, 8'h01, 8'h02, 8'h03, 8'h04, 8'h06, 8'h05,
    8'h0c, 8'h09, 8'h07, 8'h0b, 8'h08, 8'h0a, 8'h1b, 8'h18,
    8'h16, 8'h1a, 8'h17, 8'h19, 8'h1c, 8'h25, 8'h23, 8'h27,
    8'h24, 8'h26, 8'h28, 8'h30, 8'h32, 8'h2e, 8'h2f, 8'h31,
    8'h0f, 8'h34, 8'hff, 8'h0e, 8'hff, 8'h00, 8'hff, 8'hff,
    8'h70, 8'h79, 8'h73, 8'h74, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'h50, 8'hff, 8'h45, 8'hff, 8'h49, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'h41, 8'h1c, 8'hff, 8'h40, 8'h3e,
    8'hff, 8'h4d, 8'h4e, 8'h4a, 8'h4b, 8'h4c, 8'h46, 8'h47,
    8'h48, 8'h42, 8'hff, 8'h43, 8'h44, 8'h0d, 8'h33, 8'h4f,
    8'h66, 8'h67, 8'h68, 8'h64, 8'h69, 8'h6a, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h6b, 8'hff, 8'hff,
    8'hff, 8'hff, 8'h3f, 8'h3e, 8'h37, 8'h39, 8'h65, 8'h3f,
    8'h63, 8'h36, 8'h62, 8'h3b, 8'h3c, 8'h3d, 8'h3a, 8'hff
  };

  localparam logic [7:0] REPEAT_BITS [16] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f,
    8'hff, 8'hff, 8'hc1, 8'hff, 8'hc0, 8'h0f, 8'h07, 8'h07
  };

  localparam walk_row_t WALK [WALK_ROWS] = '{
    '{kms_pkg::OP_DEACTIVATE, 4'd0, 8'h00, 32'd0, ROW_ONE, '{7'h00, 1'b0, 1'b1, 1'b1}},
    '{kms_pkg::OP_DEACTIVATE, 4'd0, 8'h00, 32'd0, ROW_NONE, '0},
    '{kms_pkg::OP_SCAN, 4'd0, 8'hff, 32'd0, ROW_NONE, '0},
    '{kms_pkg::OP_ACTIVATE, 4'd0, 8'h00, 32'd0, ROW_NONE, '0},
    '{kms_pkg::OP_ACTIVATE, 4'd0, 8'h00, 32'd0, ROW_NONE, '0},
    '{OP_UNUSED, 4'd5, 8'hff, 32'd0, ROW_NONE, '0},
    '{kms_pkg::OP_SCAN, 4'd0, 8'h01, 32'd100, ROW_ONE, '{7'h1d, 1'b0, 1'b0, 1'b1}},
    '{kms_pkg::OP_SCAN, 4'd15, 8'h00, 32'd100, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd15, 8'h00, 32'd600, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd15, 8'h00, 32'd639, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd15, 8'h00, 32'd640, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd0, 8'h00, 32'd700, ROW_ONE, '{7'h1d, 1'b1, 1'b0, 1'b1}},
    '{kms_pkg::OP_SCAN, 4'd1, 8'hff, 32'd800, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd15, 8'hff, 32'hffff_fff0, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd15, 8'hff, 32'h0000_01e4, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd15, 8'h00, 32'h0000_0200, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd1, 8'h00, 32'd900, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd2, 8'hff, 32'd1000, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd2, 8'h00, 32'd1001, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd7, 8'h55, 32'hffff_ffff, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd7, 8'haa, 32'hffff_ffff, ROW_MODEL, '0},
    '{kms_pkg::OP_SCAN, 4'd3, 8'h0f, 32'd5, ROW_MODEL, '0},
    '{kms_pkg::OP_DEACTIVATE, 4'd0, 8'h00, 32'd6, ROW_ONE, '{7'h00, 1'b0, 1'b1, 1'b1}},
    '{kms_pkg::OP_ACTIVATE, 4'd0, 8'h00, 32'd7, ROW_NONE, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  kms_scan_if scan();
  kms_result_if result();
  kms_cfg_if cfg();

  key_matrix_scan_with_repeat i_dut (
    .clk(clk),
    .rst(rst),
    .scan(scan),
    .result(result),
    .cfg(cfg)
  );

  logic [7:0] map_copy [kms_pkg::KEY_BYTES];
  logic active_copy;
  logic [7:0] rep_key;
  logic [31:0] rep_base;
  logic rep_in_interval;
  logic [15:0] delay_copy;
  logic [15:0] interval_copy;

  key_res_t fresh_q[$];
  key_res_t pending_codes[$];

  logic [1:0] row_mode = ROW_MODEL;
  key_res_t row_res = '0;
  logic calm = 1'b0;
  int stall_left = 0;
  int mismatches = 0;
  int requests_done = 0;
  int results_seen = 0;
  int repeats_seen = 0;
  int releases_seen = 0;
  int cycles = 0;

  logic [7:0] held_map [kms_pkg::KEY_BYTES];
  logic gen_active;
  logic [31:0] clock_ms;
  logic [15:0] delay_set;
  logic [15:0] interval_set;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void predict_codes(input logic [1:0] op, input logic [3:0] idx,
                                        input logic [7:0] bits, input logic [31:0] now);
    logic [7:0] changed;
    logic [7:0] code;
    logic [15:0] wait_ms;
    fresh_q.delete();
    case (op)
      kms_pkg::OP_ACTIVATE: begin
        active_copy = 1'b1;
      end
      kms_pkg::OP_DEACTIVATE: begin
        if (active_copy) begin
          active_copy = 1'b0;
          foreach (map_copy[i]) map_copy[i] = 8'h00;
          rep_key = kms_pkg::NO_KEY;
          fresh_q.push_back('{7'h00, 1'b0, 1'b1, 1'b0});
          releases_seen++;
        end
      end
      kms_pkg::OP_SCAN: begin
        if (active_copy) begin
          changed = map_copy[idx] ^ bits;
          map_copy[idx] = bits;
          for (int j = 0; j < 8; j++) begin
            code = CODE_TABLE[{idx, 3'(j)}];
            if (changed[j] && code != kms_pkg::UNMAPPED) begin
              if (bits[j]) begin
                fresh_q.push_back('{code[6:0], 1'b0, 1'b0, 1'b0});
                if (REPEAT_BITS[code[6:3]][3'd7 - code[2:0]]) begin
                  rep_key = code;
                  rep_base = now;
                  rep_in_interval = 1'b0;
                end
              end else begin
                if (rep_key == code) rep_key = kms_pkg::NO_KEY;
                fresh_q.push_back('{code[6:0], 1'b1, 1'b0, 1'b0});
              end
            end
          end
          if (idx == kms_pkg::LAST_BYTE && rep_key != kms_pkg::NO_KEY) begin
            wait_ms = rep_in_interval ? interval_copy : delay_copy;
            if (now - rep_base >= {16'h0000, wait_ms}) begin
              fresh_q.push_back('{rep_key[6:0], 1'b0, 1'b0, 1'b0});
              rep_base = now;
              rep_in_interval = 1'b1;
              repeats_seen++;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input key_res_t want, input key_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected code %02h break %0b all %0b last %0b",
               what, want.scancode, want.is_break, want.all_release, want.last);
      $display("  got code %02h break %0b all %0b last %0b",
               got.scancode, got.is_break, got.all_release, got.last);
    end
  endtask

  always @(posedge clk) begin : watch
    key_res_t want;
    key_res_t got;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == kms_pkg::REG_INITIAL_DELAY) delay_copy = cfg.data;
        else interval_copy = cfg.data;
      end
      if (scan.valid && scan.ready) begin
        predict_codes(scan.opcode, scan.byte_index, scan.key_bits, scan.now_ms);
        if (row_mode != ROW_MODEL) begin
          fresh_q.delete();
          if (row_mode == ROW_ONE) fresh_q.push_back(row_res);
        end
        foreach (fresh_q[i]) pending_codes.push_back(fresh_q[i]);
        requests_done++;
      end
      if (result.valid && result.ready) begin
        got = '{result.scancode, result.is_break, result.all_release, result.last};
        results_seen++;
        if (pending_codes.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_codes.pop_front();
          if (got !== want) report_mismatch("wrong result", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("run stopped at cycle limit with %0d results outstanding",
               pending_codes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      result.ready = (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [3:0] idx,
                              input logic [7:0] bits, input logic [31:0] now,
                              input logic [1:0] mode, input key_res_t res);
    if (!calm && $urandom_range(0, 4) == 0) begin
      scan.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    scan.opcode = op;
    scan.byte_index = idx;
    scan.key_bits = bits;
    scan.now_ms = now;
    row_mode = mode;
    row_res = res;
    scan.valid = 1'b1;
    do @(posedge clk); while (!scan.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg.index = idx;
    cfg.data = val;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic settle();
    scan.valid = 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int count);
    int sent;
    int unsigned longest;
    logic [1:0] op;
    logic [3:0] idx;
    logic [7:0] bits;
    sent = 0;
    longest = 32'((delay_set > interval_set) ? delay_set : interval_set);
    while (sent < count) begin
      if ($urandom_range(0, 11) == 0) begin
        op = 2'($urandom_range(0, 3));
        idx = 4'($urandom);
        bits = 8'($urandom);
        send_request(op, idx, bits, clock_ms, ROW_MODEL, '0);
        if (gen_active && (op == kms_pkg::OP_SCAN || op == kms_pkg::OP_DEACTIVATE)) sent++;
        if (op == kms_pkg::OP_SCAN && gen_active) held_map[idx] = bits;
        if (op == kms_pkg::OP_ACTIVATE) gen_active = 1'b1;
        if (op == kms_pkg::OP_DEACTIVATE) begin
          gen_active = 1'b0;
          if ($urandom_range(0, 1) == 0) foreach (held_map[i]) held_map[i] = 8'h00;
        end
      end else if (!gen_active) begin
        if ($urandom_range(0, 3) != 0) begin
          send_request(kms_pkg::OP_ACTIVATE, 4'd0, 8'h00, clock_ms, ROW_MODEL, '0);
          gen_active = 1'b1;
        end else begin
          send_request(kms_pkg::OP_SCAN, 4'($urandom), 8'($urandom), clock_ms,
                       ROW_MODEL, '0);
        end
      end else begin
        for (int b = 0; b < kms_pkg::KEY_BYTES; b++) begin
          if (b == kms_pkg::KEY_BYTES - 1 || $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
              0, 1, 2: held_map[b] = held_map[b] ^ (8'h01 << $urandom_range(0, 7));
              3: held_map[b] = 8'($urandom);
              4: held_map[b] = 8'h00;
              default: begin
              end
            endcase
            send_request(kms_pkg::OP_SCAN, 4'(b), held_map[b], clock_ms, ROW_MODEL, '0);
            sent++;
            clock_ms = clock_ms + $urandom_range(0, 2);
          end
        end
        if ($urandom_range(0, 3) == 0) clock_ms = clock_ms + $urandom_range(0, 2 * longest + 8);
        else clock_ms = clock_ms + $urandom_range(0, interval_set / 2 + 4);
      end
    end
  endtask

  initial begin
    int settings_used;
    scan.valid = 1'b0;
    scan.opcode = kms_pkg::OP_SCAN;
    scan.byte_index = 4'd0;
    scan.key_bits = 8'h00;
    scan.now_ms = 32'd0;
    cfg.valid = 1'b0;
    cfg.index = kms_pkg::REG_INITIAL_DELAY;
    cfg.data = 16'h0000;
    foreach (map_copy[i]) map_copy[i] = 8'h00;
    foreach (held_map[i]) held_map[i] = 8'h00;
    active_copy = 1'b1;
    rep_key = kms_pkg::NO_KEY;
    rep_base = 32'd0;
    rep_in_interval = 1'b0;
    delay_copy = kms_pkg::RESET_DELAY_MS;
    interval_copy = kms_pkg::RESET_INTERVAL_MS;
    gen_active = 1'b1;
    settings_used = 1;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < WALK_ROWS; r++) begin
      send_request(WALK[r].op, WALK[r].idx, WALK[r].bits, WALK[r].now,
                   WALK[r].mode, WALK[r].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      clock_ms = $urandom;
      case (p)
        0: begin
          delay_set = 16'd0;
          interval_set = 16'd0;
        end
        1: begin
          delay_set = 16'hffff;
          interval_set = 16'hffff;
        end
        2: begin
          delay_set = 16'($urandom_range(1, 80));
          interval_set = 16'($urandom_range(1, 30));
        end
        3: begin
          delay_set = kms_pkg::RESET_DELAY_MS;
          interval_set = kms_pkg::RESET_INTERVAL_MS;
        end
        4: begin
          delay_set = 16'($urandom);
          interval_set = 16'($urandom);
        end
        default: begin
          delay_set = 16'd20;
          interval_set = 16'd0;
          clock_ms = 32'hffff_fe00;
          calm = 1'b1;
        end
      endcase
      settle();
      write_reg(kms_pkg::REG_INITIAL_DELAY, delay_set);
      write_reg(kms_pkg::REG_REPEAT_INTERVAL, interval_set);
      run_phase(PHASE_ITEMS);
      settings_used++;
    end

    settle();
    $display("%0d requests over %0d repeat settings gave %0d results",
             requests_done, settings_used, results_seen);
    $display("%0d automatic repeats, %0d all-release markers, %0d mismatches",
             repeats_seen, releases_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
